@@ hw/rtl/prdec_pkg.sv @@
// shared types and constants for the palette bitmap stream decoder
package prdec_pkg;

   localparam logic [2:0] KIND_HEADER    = 3'd0;
   localparam logic [2:0] KIND_PALETTE   = 3'd1;
   localparam logic [2:0] KIND_RUN       = 3'd2;
   localparam logic [2:0] KIND_DONE      = 3'd3;
   localparam logic [2:0] KIND_BAD_MAGIC = 3'd4;
   localparam logic [2:0] KIND_BAD_DEPTH = 3'd5;

   localparam int RSP_DATA_BITS = 88;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  palette_index;
      logic [7:0]  value_a;
      logic [7:0]  value_b;
      logic [7:0]  value_c;
      logic        pair_flag;
      logic [7:0]  run_length;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [7:0]  bits_per_pixel;
      logic        rle_coded;
      logic        last_result;
   } result_type;

   // up to two results caused by one input word
   typedef struct packed {
      result_type r0;
      result_type r1;
      logic       two;
   } pair_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] v;
      case (idx)
         2'd0: v = 8'h50;
         2'd1: v = 8'h49;
         2'd2: v = 8'h43;
         2'd3: v = 8'h54;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/prdec_parser.sv @@
// input register and single-pass file parser producing up to two results per word
module prdec_parser
   import prdec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       in_sof,
   input  logic       push_space,
   output logic       push_valid,
   output pair_type   push_pair
);

   localparam logic [2:0] PH_MAGIC   = 3'd0;
   localparam logic [2:0] PH_HEADER  = 3'd1;
   localparam logic [2:0] PH_PALETTE = 3'd2;
   localparam logic [2:0] PH_PIXELS  = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;
   localparam logic [2:0] PH_HALT    = 3'd5;

   logic        in_vld_ff, in_vld_in;
   logic [7:0]  byte_ff;
   logic        sof_ff;
   logic        fire;

   logic [2:0]  phase_ff, phase_in;
   logic [3:0]  hoff_ff, hoff_in;
   logic        coded_ff, coded_in;
   logic [7:0]  depth_ff, depth_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [8:0]  pal_ff, pal_in;
   logic [1:0]  slot_ff, slot_in;
   logic [7:0]  held0_ff, held0_in;
   logic [7:0]  held1_ff, held1_in;
   logic [7:0]  pend_ff, pend_in;
   logic [31:0] remain_ff, remain_in;
   logic [31:0] size_ff, size_in;
   logic [16:0] row_sum;
   logic [15:0] per_row;

   logic [2:0]  c_phase;
   logic [3:0]  c_hoff;
   logic        do_emit;
   logic [7:0]  run_len;
   logic [7:0]  clip;
   logic [8:0]  pal_limit;
   logic [1:0]  n_res;
   result_type  r0, r1;

   assign fire       = in_vld_ff && push_space;
   assign in_ready   = !in_vld_ff || fire;
   assign push_valid = fire && (n_res != 2'd0);
   assign push_pair  = '{r0: r0, r1: r1, two: (n_res == 2'd2)};

   always_comb begin
      in_vld_in = in_vld_ff;
      if (in_valid && in_ready) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   // image size in bytes, settled long before the palette ends
   assign row_sum = {1'b0, width_ff} + 17'd1;
   assign per_row = (depth_ff == 8'd4) ? row_sum[16:1] : width_ff;
   assign size_in = per_row * height_ff;

   always_comb begin
      c_phase   = sof_ff ? PH_MAGIC : phase_ff;
      c_hoff    = sof_ff ? 4'd0 : hoff_ff;
      phase_in  = c_phase;
      hoff_in   = c_hoff;
      coded_in  = coded_ff;
      depth_in  = depth_ff;
      width_in  = width_ff;
      height_in = height_ff;
      pal_in    = pal_ff;
      slot_in   = slot_ff;
      held0_in  = held0_ff;
      held1_in  = held1_ff;
      pend_in   = pend_ff;
      remain_in = remain_ff;
      r0        = '0;
      r1        = '0;
      n_res     = 2'd0;
      do_emit   = 1'b0;
      run_len   = 8'd1;
      clip      = 8'd0;
      pal_limit = (depth_ff == 8'd8) ? 9'd256 : 9'd16;

      case (c_phase)
         PH_MAGIC: begin
            if (byte_ff != magic_byte(c_hoff[1:0])) begin
               r0.kind  = KIND_BAD_MAGIC;
               n_res    = 2'd1;
               phase_in = PH_HALT;
            end else if (c_hoff >= 4'd3) begin
               hoff_in  = 4'd4;
               phase_in = PH_HEADER;
            end else begin
               hoff_in = c_hoff + 4'd1;
            end
         end
         PH_HEADER: begin
            case (c_hoff)
               4'd4: coded_in = (byte_ff == 8'd1);
               4'd5: depth_in = byte_ff;
               4'd6: width_in = {width_ff[15:8], byte_ff};
               4'd7: width_in = {byte_ff, width_ff[7:0]};
               4'd8: height_in = {height_ff[15:8], byte_ff};
               4'd9: height_in = {byte_ff, height_ff[7:0]};
               default: ;
            endcase
            if (c_hoff >= 4'd13) begin
               r0.kind           = KIND_HEADER;
               r0.image_width    = width_in;
               r0.image_height   = height_in;
               r0.bits_per_pixel = depth_in;
               r0.rle_coded      = coded_in;
               n_res             = 2'd1;
               if (depth_in != 8'd4 && depth_in != 8'd8) begin
                  r1.kind           = KIND_BAD_DEPTH;
                  r1.bits_per_pixel = depth_in;
                  n_res             = 2'd2;
                  phase_in          = PH_HALT;
               end else begin
                  pal_in   = 9'd0;
                  slot_in  = 2'd0;
                  phase_in = PH_PALETTE;
               end
            end else begin
               hoff_in = c_hoff + 4'd1;
            end
         end
         PH_PALETTE: begin
            if (slot_ff < 2'd2) begin
               if (slot_ff[0]) begin
                  held1_in = byte_ff;
               end else begin
                  held0_in = byte_ff;
               end
               slot_in = slot_ff + 2'd1;
            end else begin
               r0.kind          = KIND_PALETTE;
               r0.palette_index = pal_ff[7:0];
               r0.value_a       = {held0_ff[5:0], 2'b00};
               r0.value_b       = {held1_ff[5:0], 2'b00};
               r0.value_c       = {byte_ff[5:0], 2'b00};
               n_res            = 2'd1;
               slot_in          = 2'd0;
               pal_in           = pal_ff + 9'd1;
               if (pal_in >= pal_limit) begin
                  remain_in = size_ff;
                  pend_in   = 8'd0;
                  if (size_ff == 32'd0) begin
                     r1.kind  = KIND_DONE;
                     n_res    = 2'd2;
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = PH_PIXELS;
                  end
               end
            end
         end
         PH_PIXELS: begin
            if (!coded_ff) begin
               do_emit = 1'b1;
            end else if (slot_ff == 2'd0) begin
               pend_in = byte_ff;
               slot_in = 2'd1;
            end else begin
               slot_in = 2'd0;
               run_len = pend_ff;
               do_emit = 1'b1;
            end
         end
         default: ;
      endcase

      // run clipped at the image end
      if (do_emit) begin
         clip = ({24'd0, run_len} < remain_ff) ? run_len : remain_ff[7:0];
         if (clip != 8'd0) begin
            r0.kind       = KIND_RUN;
            r0.run_length = clip;
            if (depth_ff == 8'd4) begin
               r0.value_a   = {4'd0, byte_ff[7:4]};
               r0.value_b   = {4'd0, byte_ff[3:0]};
               r0.pair_flag = 1'b1;
            end else begin
               r0.value_a = byte_ff;
            end
            n_res     = 2'd1;
            remain_in = remain_ff - {24'd0, clip};
            if (remain_in == 32'd0) begin
               r1.kind  = KIND_DONE;
               n_res    = 2'd2;
               phase_in = PH_DONE;
            end
         end
      end

      if (n_res == 2'd1) begin
         r0.last_result = 1'b1;
      end
      if (n_res == 2'd2) begin
         r1.last_result = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         phase_ff  <= PH_MAGIC;
         hoff_ff   <= 4'd0;
         coded_ff  <= 1'b0;
         depth_ff  <= 8'd0;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
         pal_ff    <= 9'd0;
         slot_ff   <= 2'd0;
         held0_ff  <= 8'd0;
         held1_ff  <= 8'd0;
         pend_ff   <= 8'd0;
         remain_ff <= 32'd0;
      end else begin
         in_vld_ff <= in_vld_in;
         if (fire) begin
            phase_ff  <= phase_in;
            hoff_ff   <= hoff_in;
            coded_ff  <= coded_in;
            depth_ff  <= depth_in;
            width_ff  <= width_in;
            height_ff <= height_in;
            pal_ff    <= pal_in;
            slot_ff   <= slot_in;
            held0_ff  <= held0_in;
            held1_ff  <= held1_in;
            pend_ff   <= pend_in;
            remain_ff <= remain_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      if (in_valid && in_ready) begin
         byte_ff <= in_byte;
         sof_ff  <= in_sof;
      end
   end

endmodule

@@ hw/rtl/prdec_out_buf.sv @@
// result buffer: one pair sent, one queued; one word out per cycle if out_ready
module prdec_out_buf
   import prdec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   input  pair_type   push_pair,
   output logic       push_space,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic     hold_vld_ff, hold_vld_in;
   pair_type hold_ff, hold_in;
   logic     sel_ff, sel_in;
   logic     pend_vld_ff, pend_vld_in;
   pair_type pend_ff, pend_in;
   logic     hold_fin;

   assign push_space = !pend_vld_ff;
   assign out_valid  = hold_vld_ff;
   assign out_result = sel_ff ? hold_ff.r1 : hold_ff.r0;
   assign hold_fin   = hold_vld_ff && out_ready && (sel_ff || !hold_ff.two);

   always_comb begin
      hold_vld_in = hold_vld_ff;
      hold_in     = hold_ff;
      sel_in      = sel_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      if (!hold_vld_ff || hold_fin) begin
         sel_in = 1'b0;
         if (pend_vld_ff) begin
            hold_in     = pend_ff;
            hold_vld_in = 1'b1;
            pend_vld_in = 1'b0;
         end else if (push_valid) begin
            hold_in     = push_pair;
            hold_vld_in = 1'b1;
         end else begin
            hold_vld_in = 1'b0;
         end
      end else begin
         if (out_ready) begin
            sel_in = 1'b1;
         end
         if (push_valid) begin
            pend_in     = push_pair;
            pend_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         sel_ff      <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         sel_ff      <= sel_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
      pend_ff <= pend_in;
   end

endmodule

@@ hw/rtl/palette_bitmap_rle_stream_decoder.sv @@
// top level of the palette bitmap stream decoder
// usage:
//   req_ takes one file byte per word; req_tuser high marks the first byte of a file
//   and restarts the parse. rsp_ gives header info, palette entries, pixel runs,
//   image done and error words; rsp_tuser holds the kind, rsp_tlast marks the last
//   result caused by one input byte (a byte causes zero, one or two results).
//   path: a byte is registered in the input register, parsed combinationally there
//   and its first result is registered into the output buffer that drives rsp_.
//   throughput: one byte per cycle while each byte gives at most one result and
//   rsp_tready is high; a byte with two results keeps the single result port busy
//   for both, and the one-pair queue takes the next byte's results meanwhile.
//   reset: synchronous, active high; the parse waits for magic byte 0 and both
//   buffers empty. req_tready is high right after reset.
//   stall: while rsp_tready is low, results wait in the output register and one
//   queued pair; the parser then stops and req_tready drops after one more byte.
module palette_bitmap_rle_stream_decoder
   import prdec_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,  // data_byte
   input  logic                     req_tuser,  // start_of_file
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // palette_index, value_a, value_b, value_c, pair_flag, run_length,
   // image_width, image_height, bits_per_pixel, rle_coded, zero fill
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [2:0]               rsp_tuser,  // kind
   output logic                     rsp_tlast   // last_result
);

   logic       push_valid;
   logic       push_space;
   pair_type   push_pair;
   result_type res;

   prdec_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_sof     (req_tuser),
      .push_space (push_space),
      .push_valid (push_valid),
      .push_pair  (push_pair)
   );

   prdec_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_pair  (push_pair),
      .push_space (push_space),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (res)
   );

   assign rsp_tdata = {6'd0, res.rle_coded, res.bits_per_pixel, res.image_height,
                       res.image_width, res.run_length, res.pair_flag, res.value_c,
                       res.value_b, res.value_a, res.palette_index};
   assign rsp_tuser = res.kind;
   assign rsp_tlast = res.last_result;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for the palette bitmap stream decoder
module tb_top;
   import prdec_pkg::*;

   localparam int IDLE_LIMIT   = 5000;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_WORDS = 100;
   localparam int REPORT_MAX   = 10;

   localparam logic [31:0] FILE_MAGIC = 32'h5443_4950;  // file tag, first byte lowest
   localparam logic [3:0]  OFS_MAGIC_LAST = 4'd3;
   localparam logic [3:0]  OFS_CODED      = 4'd4;
   localparam logic [3:0]  OFS_DEPTH      = 4'd5;
   localparam logic [3:0]  OFS_WIDTH_LO   = 4'd6;
   localparam logic [3:0]  OFS_WIDTH_HI   = 4'd7;
   localparam logic [3:0]  OFS_HEIGHT_LO  = 4'd8;
   localparam logic [3:0]  OFS_HEIGHT_HI  = 4'd9;
   localparam logic [3:0]  OFS_LAST       = 4'd13;
   localparam logic [7:0]  DEPTH_NIBBLE   = 8'd4;
   localparam logic [7:0]  DEPTH_BYTE     = 8'd8;
   localparam logic [7:0]  CODED_FLAG     = 8'd1;
   localparam int          ENTRIES_NIBBLE = 16;
   localparam int          ENTRIES_BYTE   = 256;

   typedef enum logic [2:0] {
      ST_MAGIC, ST_HEADER, ST_PALETTE, ST_PIXELS, ST_DONE, ST_HALT
   } parse_state_type;

   typedef enum int {RX_OPEN, RX_HALF, RX_MOSTLY, RX_SPARSE} rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = 8'h00;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic [2:0]               rsp_tuser;
   logic                     rsp_tlast;

   palette_bitmap_rle_stream_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // decoder state mirror
   parse_state_type st;
   logic [3:0]   hdr_pos;
   logic         coded_q;
   logic [7:0]   depth_q;
   logic [15:0]  width_q;
   logic [15:0]  height_q;
   logic [8:0]   pal_count;
   logic [1:0]   slot;
   logic [7:0]   comp0;
   logic [7:0]   comp1;
   logic [7:0]   run_count;
   logic [31:0]  left_bytes;

   result_type   awaited_results[$];
   result_type   new0;
   result_type   new1;
   int           new_count;

   int  sent_words = 0;
   int  files_sent = 0;
   int  results_checked = 0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  holds_done = 0;
   int  burst_left = 0;
   bit  steady = 1'b0;
   bit  hold_request = 1'b0;
   bit  file_mark = 1'b0;

   function automatic logic [7:0] magic_at(input int i);
      logic [31:0] m;
      m = FILE_MAGIC >> (8 * (i % 4));
      return m[7:0];
   endfunction

   function automatic result_type blank(input logic [2:0] k);
      result_type r;
      r = '0;
      r.kind = k;
      return r;
   endfunction

   task automatic clear_parse();
      st = ST_MAGIC;
      hdr_pos = '0;
      coded_q = 1'b0;
      depth_q = '0;
      width_q = '0;
      height_q = '0;
      pal_count = '0;
      slot = '0;
      comp0 = '0;
      comp1 = '0;
      run_count = '0;
      left_bytes = '0;
   endtask

   task automatic add_result(input result_type r);
      if (new_count == 0) begin
         new0 = r;
      end else begin
         new1 = r;
      end
      new_count++;
   endtask

   task automatic pixel_run(input logic [7:0] pix, input logic [31:0] len);
      result_type r;
      logic [31:0] clip;
      clip = (len < left_bytes) ? len : left_bytes;
      if (clip != 0) begin
         r = blank(KIND_RUN);
         if (depth_q == DEPTH_NIBBLE) begin
            r.value_a = {4'h0, pix[7:4]};
            r.value_b = {4'h0, pix[3:0]};
            r.pair_flag = 1'b1;
         end else begin
            r.value_a = pix;
         end
         r.run_length = clip[7:0];
         left_bytes = left_bytes - clip;
         add_result(r);
         if (left_bytes == 0) begin
            add_result(blank(KIND_DONE));
            st = ST_DONE;
         end
      end
   endtask

   task automatic parse_file_byte(input logic [7:0] b, input logic sof);
      result_type r;
      logic [31:0] per_row;
      new_count = 0;
      if (sof) clear_parse();
      case (st)
         ST_MAGIC: begin
            if (b != magic_at(int'(hdr_pos[1:0]))) begin
               add_result(blank(KIND_BAD_MAGIC));
               st = ST_HALT;
            end else if (hdr_pos >= OFS_MAGIC_LAST) begin
               hdr_pos = OFS_CODED;
               st = ST_HEADER;
            end else begin
               hdr_pos++;
            end
         end
         ST_HEADER: begin
            case (hdr_pos)
               OFS_CODED:     coded_q = (b == CODED_FLAG);
               OFS_DEPTH:     depth_q = b;
               OFS_WIDTH_LO:  width_q[7:0] = b;
               OFS_WIDTH_HI:  width_q[15:8] = b;
               OFS_HEIGHT_LO: height_q[7:0] = b;
               OFS_HEIGHT_HI: height_q[15:8] = b;
               default: ;
            endcase
            if (hdr_pos >= OFS_LAST) begin
               r = blank(KIND_HEADER);
               r.image_width = width_q;
               r.image_height = height_q;
               r.bits_per_pixel = depth_q;
               r.rle_coded = coded_q;
               add_result(r);
               if (depth_q != DEPTH_NIBBLE && depth_q != DEPTH_BYTE) begin
                  r = blank(KIND_BAD_DEPTH);
                  r.bits_per_pixel = depth_q;
                  add_result(r);
                  st = ST_HALT;
               end else begin
                  pal_count = '0;
                  slot = '0;
                  st = ST_PALETTE;
               end
            end else begin
               hdr_pos++;
            end
         end
         ST_PALETTE: begin
            if (slot < 2) begin
               if (slot == 0) comp0 = b;
               else comp1 = b;
               slot++;
            end else begin
               r = blank(KIND_PALETTE);
               r.palette_index = pal_count[7:0];
               r.value_a = {comp0[5:0], 2'b00};
               r.value_b = {comp1[5:0], 2'b00};
               r.value_c = {b[5:0], 2'b00};
               add_result(r);
               slot = '0;
               pal_count++;
               if (pal_count >= ((depth_q == DEPTH_BYTE) ? ENTRIES_BYTE : ENTRIES_NIBBLE))
               begin
                  per_row = (depth_q == DEPTH_NIBBLE) ? (({16'h0, width_q} + 32'd1) >> 1)
                                                      : {16'h0, width_q};
                  left_bytes = per_row * {16'h0, height_q};
                  run_count = '0;
                  if (left_bytes == 0) begin
                     add_result(blank(KIND_DONE));
                     st = ST_DONE;
                  end else begin
                     st = ST_PIXELS;
                  end
               end
            end
         end
         ST_PIXELS: begin
            if (!coded_q) begin
               pixel_run(b, 32'd1);
            end else if (slot == 0) begin
               run_count = b;
               slot = 2'd1;
            end else begin
               slot = '0;
               pixel_run(b, {24'h0, run_count});
            end
         end
         default: ;
      endcase
      if (new_count == 1) begin
         new0.last_result = 1'b1;
         awaited_results.push_back(new0);
      end else if (new_count == 2) begin
         new1.last_result = 1'b1;
         awaited_results.push_back(new0);
         awaited_results.push_back(new1);
      end
   endtask

   task automatic send_word(input logic [7:0] b, input logic sof);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if (!steady) gap = $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= sof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_file_byte(b, sof);
      sent_words++;
   endtask

   function automatic logic [7:0] pick_byte();
      logic [7:0] v;
      case ($urandom_range(0, 7))
         0: v = 8'h00;
         1: v = 8'hFF;
         default: v = 8'($urandom_range(0, 255));
      endcase
      return v;
   endfunction

   function automatic logic [7:0] pick_count();
      logic [7:0] v;
      case ($urandom_range(0, 7))
         0: v = 8'h00;
         1: v = 8'hFF;
         2, 3: v = 8'($urandom_range(0, 255));
         default: v = 8'($urandom_range(1, 4));
      endcase
      return v;
   endfunction

   task automatic begin_file(input bit mark);
      file_mark = mark;
      files_sent++;
   endtask

   task automatic put(input logic [7:0] b);
      logic sof;
      sof = file_mark;
      file_mark = 1'b0;
      send_word(b, sof);
   endtask

   task automatic put_pair(input logic [7:0] cnt, input logic [7:0] pix);
      put(cnt);
      put(pix);
   endtask

   task automatic put_trailer(input int n);
      repeat (n) put(8'($urandom_range(0, 255)));
   endtask

   task automatic put_magic();
      for (int k = 0; k < 4; k++) put(magic_at(k));
   endtask

   task automatic put_header(input logic [7:0] coded_b, input logic [7:0] depth,
                             input logic [15:0] w, input logic [15:0] h);
      put(coded_b);
      put(depth);
      put(w[7:0]);
      put(w[15:8]);
      put(h[7:0]);
      put(h[15:8]);
      put_trailer(4);
   endtask

   task automatic start_image(input bit mark, input logic [7:0] coded_b,
                              input logic [7:0] depth, input logic [15:0] w,
                              input logic [15:0] h);
      begin_file(mark);
      put_magic();
      put_header(coded_b, depth, w, h);
      if (st == ST_PALETTE)
         repeat (3 * ((depth == DEPTH_BYTE) ? ENTRIES_BYTE : ENTRIES_NIBBLE)) put(pick_byte());
   endtask

   task automatic put_pixels(input int budget);
      while (st == ST_PIXELS && budget > 0) begin
         if (coded_q) put_pair(pick_count(), pick_byte());
         else put(pick_byte());
         budget--;
      end
   endtask

   task automatic test_unmarked_first_file();
      start_image(1'b0, CODED_FLAG, DEPTH_NIBBLE, 16'd3, 16'd1);
      put_pair(8'h00, 8'h5A);
      put_pair(8'hFF, 8'hA5);
      put_trailer(2);
   endtask

   task automatic test_bad_magic();
      for (int pos = 0; pos < 4; pos++) begin
         begin_file(1'b1);
         for (int k = 0; k < pos; k++) put(magic_at(k));
         put(magic_at(pos) ^ 8'($urandom_range(1, 255)));
         put(magic_at(0));
         put_trailer(2);
      end
   endtask

   task automatic test_bad_depth();
      logic [7:0] d;
      for (int i = 0; i < 4; i++) begin
         case (i)
            0: d = 8'd0;
            1: d = 8'd1;
            2: d = 8'd16;
            default: d = 8'hFF;
         endcase
         begin_file(1'b1);
         put_magic();
         put_header(pick_byte(), d, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
         put_trailer(3);
      end
   endtask

   task automatic test_flag_and_empty();
      // any flag other than one means raw data
      start_image(1'b1, 8'h02, DEPTH_NIBBLE, 16'd5, 16'd2);
      put_pixels(400);
      put_trailer(2);
      start_image(1'b1, CODED_FLAG, DEPTH_NIBBLE, 16'hFFFF, 16'd0);
      put_trailer(2);
      start_image(1'b1, 8'h00, DEPTH_NIBBLE, 16'd0, 16'hFFFF);
      put_trailer(1);
   endtask

   task automatic test_byte_depth();
      start_image(1'b1, CODED_FLAG, DEPTH_BYTE, 16'd3, 16'd2);
      put_pair(8'h00, 8'hFF);
      put_pair(8'h02, 8'h00);
      put_pair(8'h01, 8'hFF);
      put_pair(8'hFF, 8'h80);
      put_trailer(2);
   endtask

   task automatic test_restart();
      begin_file(1'b1);
      put_magic();
      put(CODED_FLAG);
      put(DEPTH_NIBBLE);
      put(8'h10);
      start_image(1'b1, CODED_FLAG, DEPTH_NIBBLE, 16'hFFFF, 16'hFFFF);
      repeat (4) put_pair(8'hFF, pick_byte());
      put(8'h07);
      start_image(1'b1, 8'h00, DEPTH_NIBBLE, 16'd1, 16'd1);
      put(8'hC3);
      put_trailer(1);
   endtask

   task automatic test_long_stall();
      start_image(1'b1, 8'h00, DEPTH_NIBBLE, 16'd120, 16'd1);
      steady = 1'b1;
      hold_request = 1'b1;
      put_pixels(400);
      steady = 1'b0;
   endtask

   task automatic random_image();
      logic [7:0]  coded_b;
      logic [7:0]  depth;
      logic [15:0] w;
      logic [15:0] h;
      int          shape;
      bit          big;
      case ($urandom_range(0, 3))
         0: coded_b = 8'h00;
         3: coded_b = 8'($urandom_range(0, 255));
         default: coded_b = CODED_FLAG;
      endcase
      shape = $urandom_range(0, 19);
      if (shape == 0) depth = DEPTH_BYTE;
      else if (shape == 1) depth = 8'($urandom_range(0, 255));
      else depth = DEPTH_NIBBLE;
      w = 16'($urandom_range(1, 12));
      h = 16'($urandom_range(1, 4));
      big = 1'b0;
      case ($urandom_range(0, 9))
         0: begin
            w = 16'($urandom_range(0, 65535));
            h = 16'($urandom_range(0, 65535));
            big = 1'b1;
         end
         1: h = 16'd0;
         2: w = 16'd0;
         default: ;
      endcase
      start_image(1'b1, coded_b, depth, w, h);
      put_pixels((big || $urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 400);
      put_trailer($urandom_range(0, 3));
   endtask

   task automatic random_noise();
      int n;
      logic [7:0] nb;
      n = $urandom_range(1, 24);
      begin_file(1'b1);
      for (int k = 0; k < n; k++) begin
         if (k > 0 && $urandom_range(0, 7) == 0) file_mark = 1'b1;
         if ($urandom_range(0, 1) == 1) nb = magic_at(k);
         else nb = 8'($urandom_range(0, 255));
         put(nb);
      end
   endtask

   task automatic test_random_files();
      int target;
      target = sent_words + RANDOM_WORDS;
      while (sent_words < target) begin
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 8) random_image();
         else random_noise();
      end
      steady = 1'b0;
   endtask

   // output side stall pattern
   initial begin : receiver
      int          seg_left;
      rx_mode_type mode;
      seg_left = 0;
      mode = RX_OPEN;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            if (seg_left == 0) begin
               seg_left = $urandom_range(1, 60);
               mode = rx_mode_type'($urandom_range(0, 3));
            end
            seg_left--;
            case (mode)
               RX_OPEN:   rsp_tready <= 1'b1;
               RX_HALF:   rsp_tready <= ($urandom_range(0, 1) == 1);
               RX_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
               default:   rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic string show(input result_type r);
      return $sformatf({"kind=%0d idx=%0d a=%0d b=%0d c=%0d pair=%0d run=%0d w=%0d h=%0d ",
                        "bpp=%0d rle=%0d last=%0d"},
                       r.kind, r.palette_index, r.value_a, r.value_b, r.value_c,
                       r.pair_flag, r.run_length, r.image_width, r.image_height,
                       r.bits_per_pixel, r.rle_coded, r.last_result);
   endfunction

   function automatic string diff_fields(input result_type e, input result_type g);
      string s;
      s = "";
      if (e.kind !== g.kind) s = {s, " kind"};
      if (e.palette_index !== g.palette_index) s = {s, " palette_index"};
      if (e.value_a !== g.value_a) s = {s, " value_a"};
      if (e.value_b !== g.value_b) s = {s, " value_b"};
      if (e.value_c !== g.value_c) s = {s, " value_c"};
      if (e.pair_flag !== g.pair_flag) s = {s, " pair_flag"};
      if (e.run_length !== g.run_length) s = {s, " run_length"};
      if (e.image_width !== g.image_width) s = {s, " image_width"};
      if (e.image_height !== g.image_height) s = {s, " image_height"};
      if (e.bits_per_pixel !== g.bits_per_pixel) s = {s, " bits_per_pixel"};
      if (e.rle_coded !== g.rle_coded) s = {s, " rle_coded"};
      if (e.last_result !== g.last_result) s = {s, " last_result"};
      return s;
   endfunction

   always @(posedge clock) begin : result_check
      result_type got;
      result_type want;
      string      diff;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '0;
         got.kind = rsp_tuser;
         got.palette_index = rsp_tdata[7:0];
         got.value_a = rsp_tdata[15:8];
         got.value_b = rsp_tdata[23:16];
         got.value_c = rsp_tdata[31:24];
         got.pair_flag = rsp_tdata[32];
         got.run_length = rsp_tdata[40:33];
         got.image_width = rsp_tdata[56:41];
         got.image_height = rsp_tdata[72:57];
         got.bits_per_pixel = rsp_tdata[80:73];
         got.rle_coded = rsp_tdata[81];
         got.last_result = rsp_tlast;
         results_checked++;
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected word at %0t: %s", $time, show(got));
         end else begin
            want = awaited_results.pop_front();
            diff = diff_fields(want, got);
            if (diff != "") begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX) begin
                  $display("mismatch at %0t in%s", $time, diff);
                  $display("  expected %s", show(want));
                  $display("  actual   %s", show(got));
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("no word moved for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, awaited_results.size());
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      clear_parse();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_unmarked_first_file();
      test_bad_magic();
      test_bad_depth();
      test_flag_and_empty();
      test_byte_depth();
      test_restart();
      test_long_stall();
      test_random_files();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d bytes in %0d files: bad tags, odd depths, empty, clipped, restarts",
               sent_words, files_sent);
      $display("checked %0d results with %0d mismatches, %0d long output holds",
               results_checked, mismatch_count, holds_done);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/prdec_pkg.sv
hw/rtl/prdec_parser.sv
hw/rtl/prdec_out_buf.sv
hw/rtl/palette_bitmap_rle_stream_decoder.sv
verif/tb_top.sv
